// ----- rtl/tshtd_pkg.sv -----
// ----------------------------------------------------------------------------
// tshtd_pkg
// Types, widths and codes shared by the two-side hit time difference filter.
// ----------------------------------------------------------------------------
`default_nettype none

package tshtd_pkg;

    localparam int TIME_WIDTH         = 16;
    localparam int COUNT_WIDTH        = 8;
    localparam int CELL_WARNING_LIMIT = 32;
    localparam int SUM_WIDTH          = TIME_WIDTH + COUNT_WIDTH;
    localparam int STEP_WIDTH         = $clog2(SUM_WIDTH);
    localparam int DIFF_WIDTH         = 17;
    localparam int CHARGE_WIDTH       = 16;
    localparam int ETA_WIDTH          = 12;
    localparam int ETA_MIN_WIDTH      = 11;
    localparam int HITS_WIDTH         = 8;
    localparam int CFG_INDEX_WIDTH    = 2;
    localparam int CFG_DATA_WIDTH     = 17;
    localparam int S_TDATA_WIDTH      = 56;
    localparam int M_TDATA_WIDTH      = 72;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic signed [CHARGE_WIDTH-1:0]  CHARGE_THRESHOLD_RESET = 16'sd6;
    localparam logic        [ETA_MIN_WIDTH-1:0] ETA_MINIMUM_RESET      = 11'd384;
    localparam logic        [HITS_WIDTH-1:0]    MIN_HITS_RESET         = 8'd2;
    localparam logic        [DIFF_WIDTH-1:0]    MAX_DIFF_RESET         = 17'd320;

    localparam logic signed [2:0] SIDE_A = 3'sd1;
    localparam logic signed [2:0] SIDE_C = -3'sd1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_CHARGE_THRESHOLD    = 2'd0,
        CFG_ETA_MINIMUM         = 2'd1,
        CFG_MIN_HITS_PER_SIDE   = 2'd2,
        CFG_MAX_TIME_DIFFERENCE = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_START_A,
        ST_WAIT_A,
        ST_START_C,
        ST_WAIT_C,
        ST_FINISH
    } state_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [2:0]                     pad;
        logic signed [TIME_WIDTH-1:0]   cell_time;
        logic [1:0]                     channel_number;
        logic [3:0]                     module_number;
        logic signed [2:0]              side_code;
        logic signed [ETA_WIDTH-1:0]    cell_eta;
        logic signed [CHARGE_WIDTH-1:0] cell_charge;
    } in_payload_t;

    typedef struct packed {
        logic [3:0]                   pad;
        logic                         too_many_cells;
        logic                         pass_cut;
        logic                         difference_valid;
        logic signed [DIFF_WIDTH-1:0] time_difference;
        logic [HITS_WIDTH-1:0]        hits_c;
        logic [HITS_WIDTH-1:0]        hits_a;
        logic signed [TIME_WIDTH-1:0] mean_time_c;
        logic signed [TIME_WIDTH-1:0] mean_time_a;
    } out_payload_t;

    typedef struct packed {
        logic signed [CHARGE_WIDTH-1:0] charge_threshold;
        logic        [ETA_MIN_WIDTH-1:0] eta_minimum;
    } cut_cfg_t;

    typedef struct packed {
        logic update;
        logic clear;
    } acc_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/tshtd_divider.sv -----
// ----------------------------------------------------------------------------
// tshtd_divider
// Restoring signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero; a zero divisor yields zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tshtd_divider (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   start,
    input  wire logic signed [tshtd_pkg::SUM_WIDTH-1:0]  dividend,
    input  wire logic [tshtd_pkg::COUNT_WIDTH-1:0]      divisor,
    output logic                                        done,
    output logic signed [tshtd_pkg::TIME_WIDTH-1:0]     quotient
);
    import tshtd_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [STEP_WIDTH-1:0]  step_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [SUM_WIDTH-1:0]   quo_reg;
    logic [COUNT_WIDTH-1:0] div_reg;
    logic                   neg_reg;
    logic                   zero_reg;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;
    logic [SUM_WIDTH-1:0]   signed_quo;

    assign trial = {rem_reg, quo_reg[SUM_WIDTH-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_WIDTH'(SUM_WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend[SUM_WIDTH-1] ? SUM_WIDTH'(-dividend) : SUM_WIDTH'(dividend);
            div_reg  <= divisor;
            neg_reg  <= dividend[SUM_WIDTH-1];
            zero_reg <= (divisor == '0);
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            quo_reg <= {quo_reg[SUM_WIDTH-2:0], fits};
        end
    end

    assign signed_quo = neg_reg ? SUM_WIDTH'(-quo_reg) : quo_reg;
    assign quotient   = zero_reg ? '0 : signed_quo[TIME_WIDTH-1:0];
    assign done       = done_reg;

endmodule

`default_nettype wire

// ----- rtl/tshtd_accum.sv -----
// ----------------------------------------------------------------------------
// tshtd_accum
// Cell qualification and per-side saturating hit time sums and counts.
// ----------------------------------------------------------------------------
`default_nettype none

module tshtd_accum (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire tshtd_pkg::acc_ctrl_t                   ctrl,
    input  wire tshtd_pkg::cut_cfg_t                    cfg,
    input  wire tshtd_pkg::in_payload_t                 cell_data,
    output logic signed [tshtd_pkg::SUM_WIDTH-1:0]      sum_a,
    output logic signed [tshtd_pkg::SUM_WIDTH-1:0]      sum_c,
    output logic [tshtd_pkg::COUNT_WIDTH-1:0]           count_a,
    output logic [tshtd_pkg::COUNT_WIDTH-1:0]           count_c
);
    import tshtd_pkg::*;

    logic signed [SUM_WIDTH-1:0] sum_a_reg, sum_a_next;
    logic signed [SUM_WIDTH-1:0] sum_c_reg, sum_c_next;
    logic [COUNT_WIDTH-1:0]      count_a_reg, count_a_next;
    logic [COUNT_WIDTH-1:0]      count_c_reg, count_c_next;

    logic [ETA_WIDTH-1:0]        abs_eta;
    logic                        accept;
    logic signed [SUM_WIDTH-1:0] time_ext;

    always_comb
    begin
        abs_eta  = cell_data.cell_eta[ETA_WIDTH-1] ? ETA_WIDTH'(-cell_data.cell_eta)
                                                   : ETA_WIDTH'(cell_data.cell_eta);
        accept   = (cell_data.cell_charge >= cfg.charge_threshold) &&
                   (abs_eta >= {1'b0, cfg.eta_minimum}) &&
                   !cell_data.module_number[3] && !cell_data.channel_number[1];
        time_ext = SUM_WIDTH'(cell_data.cell_time);

        sum_a_next   = sum_a_reg;
        sum_c_next   = sum_c_reg;
        count_a_next = count_a_reg;
        count_c_next = count_c_reg;

        if (ctrl.clear)
        begin
            sum_a_next   = '0;
            sum_c_next   = '0;
            count_a_next = '0;
            count_c_next = '0;
        end
        else if (ctrl.update && accept)
        begin
            if (cell_data.side_code == SIDE_A && count_a_reg != COUNT_MAX)
            begin
                sum_a_next   = sum_a_reg + time_ext;
                count_a_next = count_a_reg + 1'b1;
            end
            else if (cell_data.side_code == SIDE_C && count_c_reg != COUNT_MAX)
            begin
                sum_c_next   = sum_c_reg + time_ext;
                count_c_next = count_c_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg   <= '0;
            sum_c_reg   <= '0;
            count_a_reg <= '0;
            count_c_reg <= '0;
        end
        else
        begin
            sum_a_reg   <= sum_a_next;
            sum_c_reg   <= sum_c_next;
            count_a_reg <= count_a_next;
            count_c_reg <= count_c_next;
        end
    end

    assign sum_a   = sum_a_reg;
    assign sum_c   = sum_c_reg;
    assign count_a = count_a_reg;
    assign count_c = count_c_reg;

endmodule

`default_nettype wire

// ----- rtl/two_side_hit_time_difference_filter.sv -----
// ----------------------------------------------------------------------------
// two_side_hit_time_difference_filter
// Per-event mean hit time on both detector sides, their difference and a
// pass flag, computed with one shared serial divider.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s       | in        | s_tvalid/s_tready  | s_tdata cell fields, s_tlast end of event
//  m       | out       | m_tvalid/m_tready  | m_tdata event result
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  A cell is captured, then qualified and accumulated.
//  A last cell adds two 24-step divisions on the shared divider, side A first,
//  then side C, and a finish state.
//  The result sits in an output register; the next event is accepted meanwhile,
//  and the finish state waits only if that register is still full.
//  Reset is asynchronous; cell, mean and result data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module two_side_hit_time_difference_filter (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    output logic                                         s_tready,
    // cell_charge, cell_eta, side_code, module_number, channel_number, cell_time
    input  wire logic [tshtd_pkg::S_TDATA_WIDTH-1:0]     s_tdata,
    input  wire logic                                    s_tlast,
    output logic                                         m_tvalid,
    input  wire logic                                    m_tready,
    // mean_time_a, mean_time_c, hits_a, hits_c, time_difference,
    // difference_valid, pass_cut, too_many_cells
    output logic [tshtd_pkg::M_TDATA_WIDTH-1:0]          m_tdata,
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [tshtd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [tshtd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
    import tshtd_pkg::*;

    state_t state_reg, state_next;

    logic signed [CHARGE_WIDTH-1:0] charge_threshold_reg;
    logic [ETA_MIN_WIDTH-1:0]       eta_minimum_reg;
    logic [HITS_WIDTH-1:0]          min_hits_reg;
    logic [DIFF_WIDTH-1:0]          max_diff_reg;

    in_payload_t                    cell_reg;
    logic                           last_reg;
    logic signed [TIME_WIDTH-1:0]   mean_a_reg;
    logic signed [TIME_WIDTH-1:0]   mean_c_reg;
    logic                           out_valid_reg;
    out_payload_t                   out_reg;

    acc_ctrl_t                      acc_ctrl;
    cut_cfg_t                       cut_cfg;
    logic signed [SUM_WIDTH-1:0]    sum_a, sum_c;
    logic [COUNT_WIDTH-1:0]         count_a, count_c;

    logic                           div_start;
    logic                           div_sel_c;
    logic                           div_done;
    logic signed [TIME_WIDTH-1:0]   div_quotient;
    logic                           load_out;

    logic                           valid;
    logic signed [DIFF_WIDTH-1:0]   diff;
    logic [DIFF_WIDTH-1:0]          abs_diff;
    logic [COUNT_WIDTH:0]           total_hits;

    assign cut_cfg.charge_threshold = charge_threshold_reg;
    assign cut_cfg.eta_minimum      = eta_minimum_reg;

    tshtd_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (acc_ctrl),
        .cfg       (cut_cfg),
        .cell_data (cell_reg),
        .sum_a     (sum_a),
        .sum_c     (sum_c),
        .count_a   (count_a),
        .count_c   (count_c)
    );

    tshtd_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_sel_c ? sum_c : sum_a),
        .divisor  (div_sel_c ? count_c : count_a),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        acc_ctrl      = '0;
        div_start     = 1'b0;
        div_sel_c     = 1'b0;
        load_out      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                acc_ctrl.update = 1'b1;
                state_next      = last_reg ? ST_START_A : ST_IDLE;
            end
            ST_START_A:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (div_done)
                    state_next = ST_START_C;
            end
            ST_START_C:
            begin
                div_sel_c  = 1'b1;
                div_start  = 1'b1;
                state_next = ST_WAIT_C;
            end
            ST_WAIT_C:
            begin
                div_sel_c = 1'b1;
                if (div_done)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out       = 1'b1;
                    acc_ctrl.clear = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            charge_threshold_reg <= CHARGE_THRESHOLD_RESET;
            eta_minimum_reg      <= ETA_MINIMUM_RESET;
            min_hits_reg         <= MIN_HITS_RESET;
            max_diff_reg         <= MAX_DIFF_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CHARGE_THRESHOLD:    charge_threshold_reg <= cfg_data[CHARGE_WIDTH-1:0];
                CFG_ETA_MINIMUM:         eta_minimum_reg      <= cfg_data[ETA_MIN_WIDTH-1:0];
                CFG_MIN_HITS_PER_SIDE:   min_hits_reg         <= cfg_data[HITS_WIDTH-1:0];
                CFG_MAX_TIME_DIFFERENCE: max_diff_reg         <= cfg_data[DIFF_WIDTH-1:0];
                default:                 ;
            endcase
        end
    end

    // capture the cell and the divider results
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cell_reg <= in_payload_t'(s_tdata);
            last_reg <= s_tlast;
        end
        if (div_done && !div_sel_c)
            mean_a_reg <= div_quotient;
        if (div_done && div_sel_c)
            mean_c_reg <= div_quotient;
    end

    // event result
    always_comb
    begin
        valid      = (HITS_WIDTH'(count_a) >= min_hits_reg) &&
                     (HITS_WIDTH'(count_c) >= min_hits_reg);
        diff       = valid ? (DIFF_WIDTH'(mean_a_reg) - DIFF_WIDTH'(mean_c_reg)) : '0;
        abs_diff   = diff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-diff) : DIFF_WIDTH'(diff);
        total_hits = {1'b0, count_a} + {1'b0, count_c};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg.pad              <= '0;
            out_reg.mean_time_a      <= mean_a_reg;
            out_reg.mean_time_c      <= mean_c_reg;
            out_reg.hits_a           <= HITS_WIDTH'(count_a);
            out_reg.hits_c           <= HITS_WIDTH'(count_c);
            out_reg.time_difference  <= diff;
            out_reg.difference_valid <= valid;
            out_reg.pass_cut         <= valid && (abs_diff < max_diff_reg);
            out_reg.too_many_cells   <= int'(total_hits) > CELL_WARNING_LIMIT;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_WIDTH'(out_reg);

endmodule

`default_nettype wire

// ----- rtl/tshtd_checker.sv -----
// ----------------------------------------------------------------------------
// tshtd_checker
// Port-level checks on the two-side hit time difference filter.
// ----------------------------------------------------------------------------
`default_nettype none

module tshtd_checker (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    s_tvalid,
    input  wire logic                                    s_tready,
    input  wire logic                                    m_tvalid,
    input  wire logic                                    m_tready,
    input  wire logic [tshtd_pkg::M_TDATA_WIDTH-1:0]     m_tdata
);
    import tshtd_pkg::*;

    out_payload_t res;
    assign res = out_payload_t'(m_tdata);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // drop ready after an accepted cell
    a_busy_after_cell: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready right after an accepted cell");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !res.difference_valid |-> res.time_difference == '0 && !res.pass_cut)
        else $error("invalid difference not zeroed");

    a_warning: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.too_many_cells |->
            (int'(res.hits_a) + int'(res.hits_c)) > CELL_WARNING_LIMIT)
        else $error("cell warning without enough hits");

endmodule

bind two_side_hit_time_difference_filter tshtd_checker u_tshtd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);

`default_nettype wire

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-side hit time difference filter. Cells go
// in on the slave stream, event summaries come out on the master stream. A
// behavioral model of the per-side sums, counts, means and cuts predicts
// the summary of every random event. The run starts with a short table of
// hand-picked cells and their expected summaries, then moves through several
// register settings with random events. Both streams see random gaps and
// back-pressure, and one long output stall fills the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import tshtd_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int PHASE_CELLS   = 145;
    localparam int STALL_CYCLES  = 600;
    localparam int MAX_MODULE    = 7;
    localparam int MAX_CHANNEL   = 1;
    localparam int ETA_LIMIT     = 1280;

    localparam logic signed [2:0] SIDE_NONE    = 3'sd0;
    localparam logic signed [2:0] SIDE_BAD_POS = 3'sd3;
    localparam logic signed [2:0] SIDE_BAD_NEG = -3'sd4;

    typedef struct {
        in_payload_t  cell_item;
        logic         last;
        logic         typed;
        out_payload_t want;
    } stim_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       s_tvalid;
    logic                       s_tready;
    logic [S_TDATA_WIDTH-1:0]   s_tdata;
    logic                       s_tlast;
    logic                       m_tvalid;
    logic                       m_tready;
    logic [M_TDATA_WIDTH-1:0]   m_tdata;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    // cut settings and per-event accumulators of the model
    int cut_charge;
    int cut_eta;
    int need_hits;
    int diff_limit;
    int sum_a;
    int sum_c;
    int count_a;
    int count_c;

    out_payload_t event_summaries_due[$];
    stim_row_t    directed_rows[$];

    int error_count = 0;
    int results_checked = 0;
    int cells_accepted;
    int events_sent;
    int saturated_cells;
    int events_passed;
    int events_crowded;
    logic pressure_done = 1'b0;

    two_side_hit_time_difference_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic in_payload_t make_cell(int charge, int eta, logic signed [2:0] side,
                                              int mod_num, int chan, int hit_time);
        in_payload_t c;
        c                = '0;
        c.cell_charge    = CHARGE_WIDTH'(charge);
        c.cell_eta       = ETA_WIDTH'(eta);
        c.side_code      = side;
        c.module_number  = 4'(mod_num);
        c.channel_number = 2'(chan);
        c.cell_time      = TIME_WIDTH'(hit_time);
        return c;
    endfunction

    function automatic out_payload_t make_summary(int mean_a, int mean_c, int hits_a,
                                                  int hits_c, int diff, logic valid,
                                                  logic pass, logic many);
        out_payload_t r;
        r                  = '0;
        r.mean_time_a      = TIME_WIDTH'(mean_a);
        r.mean_time_c      = TIME_WIDTH'(mean_c);
        r.hits_a           = HITS_WIDTH'(hits_a);
        r.hits_c           = HITS_WIDTH'(hits_c);
        r.time_difference  = DIFF_WIDTH'(diff);
        r.difference_valid = valid;
        r.pass_cut         = pass;
        r.too_many_cells   = many;
        return r;
    endfunction

    // accumulate one cell; on the end of an event form the summary and clear
    function automatic logic accumulate_cell(input in_payload_t c, input logic last,
                                             output out_payload_t r);
        int   charge;
        int   abs_eta;
        int   mean_a;
        int   mean_c;
        int   diff;
        int   abs_diff;
        logic take;
        logic valid;
        logic pass;
        logic many;
        charge  = int'($signed(c.cell_charge));
        abs_eta = int'($signed(c.cell_eta));
        if (abs_eta < 0)
        begin
            abs_eta = -abs_eta;
        end
        take = (charge >= cut_charge) && (abs_eta >= cut_eta) &&
               (c.side_code == SIDE_A || c.side_code == SIDE_C) &&
               (int'(c.module_number) <= MAX_MODULE) && (int'(c.channel_number) <= MAX_CHANNEL);
        if (take && c.side_code == SIDE_A)
        begin
            if (count_a < int'(COUNT_MAX))
            begin
                sum_a   += int'($signed(c.cell_time));
                count_a += 1;
            end
            else
            begin
                saturated_cells++;
            end
        end
        else if (take)
        begin
            if (count_c < int'(COUNT_MAX))
            begin
                sum_c   += int'($signed(c.cell_time));
                count_c += 1;
            end
            else
            begin
                saturated_cells++;
            end
        end
        r = '0;
        if (!last)
        begin
            return 1'b0;
        end
        mean_a   = (count_a != 0) ? sum_a / count_a : 0;
        mean_c   = (count_c != 0) ? sum_c / count_c : 0;
        valid    = (count_a >= need_hits) && (count_c >= need_hits);
        diff     = valid ? mean_a - mean_c : 0;
        abs_diff = (diff < 0) ? -diff : diff;
        pass     = valid && (abs_diff < diff_limit);
        many     = (count_a + count_c) > CELL_WARNING_LIMIT;
        r        = make_summary(mean_a, mean_c, count_a, count_c, diff, valid, pass, many);
        if (pass)
        begin
            events_passed++;
        end
        if (many)
        begin
            events_crowded++;
        end
        sum_a   = 0;
        sum_c   = 0;
        count_a = 0;
        count_c = 0;
        return 1'b1;
    endfunction

    function automatic void compare_field(string field, longint want_v, longint got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
            error_count++;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_cell(input in_payload_t cell_item, input logic last, input int gap,
                             input logic typed, input out_payload_t want);
        out_payload_t summary;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cell_item;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        cells_accepted++;
        if (accumulate_cell(cell_item, last, summary))
        begin
            event_summaries_due.push_back(typed ? want : summary);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        logic [CFG_DATA_WIDTH-1:0] bits;
        bits = (idx == CFG_CHARGE_THRESHOLD) ? {1'b0, value[15:0]} : value[16:0];
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= bits;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_CHARGE_THRESHOLD:    cut_charge = int'($signed(bits[15:0]));
            CFG_ETA_MINIMUM:         cut_eta    = int'(bits[10:0]);
            CFG_MIN_HITS_PER_SIDE:   need_hits  = int'(bits[7:0]);
            CFG_MAX_TIME_DIFFERENCE: diff_limit = int'(bits);
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (event_summaries_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic int pick_gap(logic burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 55)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 40);
    endfunction

    // mostly cells that pass every cut, the rest broken in one field or pure noise
    function automatic in_payload_t rand_cell(int side_a_pct, int base_a, int base_c,
                                              logic clean);
        in_payload_t c;
        int   kind;
        int   mag;
        int   hit_time;
        logic on_a;
        kind = clean ? 0 : $urandom_range(0, 99);
        c    = '0;
        on_a = $urandom_range(0, 99) < side_a_pct;
        if ($urandom_range(0, 7) == 0)
        begin
            c.cell_charge = CHARGE_WIDTH'(cut_charge);
        end
        else
        begin
            c.cell_charge = CHARGE_WIDTH'(cut_charge + $urandom_range(0, 32767 - cut_charge));
        end
        mag              = $urandom_range(cut_eta, ETA_LIMIT);
        c.cell_eta       = ETA_WIDTH'($urandom_range(0, 1) ? -mag : mag);
        c.side_code      = on_a ? SIDE_A : SIDE_C;
        c.module_number  = 4'($urandom_range(0, MAX_MODULE));
        c.channel_number = 2'($urandom_range(0, MAX_CHANNEL));
        hit_time         = (on_a ? base_a : base_c) + $urandom_range(0, 200) - 100;
        if ($urandom_range(0, 7) == 0)
        begin
            hit_time = $urandom_range(0, 65535) - 32768;
        end
        c.cell_time = TIME_WIDTH'(hit_time);
        if (kind >= 80 && kind < 90)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    if (cut_charge > -32768)
                    begin
                        c.cell_charge = CHARGE_WIDTH'(cut_charge - 1 - $urandom_range(0, 3));
                    end
                end
                1:
                begin
                    if (cut_eta > 0)
                    begin
                        mag        = $urandom_range(0, cut_eta - 1);
                        c.cell_eta = ETA_WIDTH'($urandom_range(0, 1) ? -mag : mag);
                    end
                end
                2:
                begin
                    c.side_code = 3'($urandom_range(0, 7));
                    if (c.side_code == SIDE_A || c.side_code == SIDE_C)
                    begin
                        c.side_code = SIDE_NONE;
                    end
                end
                3:       c.module_number  = 4'($urandom_range(MAX_MODULE + 1, 15));
                default: c.channel_number = 2'($urandom_range(MAX_CHANNEL + 1, 3));
            endcase
        end
        else if (kind >= 90)
        begin
            c.cell_charge    = CHARGE_WIDTH'($urandom);
            c.cell_eta       = ETA_WIDTH'($urandom_range(0, 2 * ETA_LIMIT) - ETA_LIMIT);
            c.side_code      = 3'($urandom);
            c.module_number  = 4'($urandom);
            c.channel_number = 2'($urandom);
            c.cell_time      = TIME_WIDTH'($urandom);
        end
        return c;
    endfunction

    task automatic run_event(input int len, input logic clean);
        in_payload_t c;
        int   base_a;
        int   base_c;
        int   side_a_pct;
        int   k;
        logic burst;
        burst  = ($urandom_range(0, 3) == 0);
        base_a = $urandom_range(0, 32000) - 16000;
        if ($urandom_range(0, 1))
        begin
            base_c = base_a + $urandom_range(0, 800) - 400;
        end
        else
        begin
            base_c = $urandom_range(0, 32000) - 16000;
        end
        side_a_pct = clean ? 50 : $urandom_range(0, 100);
        for (k = 0; k < len; k++)
        begin
            c = rand_cell(side_a_pct, base_a, base_c, clean);
            send_cell(c, k == len - 1, pick_gap(burst), 1'b0, '0);
        end
        events_sent++;
    endtask

    task automatic set_phase(input int phase);
        int thr;
        int eta_min;
        int hits;
        int limit;
        case (phase)
            1:
            begin
                thr = -32768; eta_min = 0; hits = 0; limit = 131071;
            end
            2:
            begin
                thr = 32767; eta_min = ETA_LIMIT; hits = 255; limit = 0;
            end
            3:
            begin
                thr     = $urandom_range(0, 65535) - 32768;
                eta_min = $urandom_range(0, ETA_LIMIT);
                hits    = $urandom_range(0, 6);
                limit   = $urandom_range(0, 2000);
            end
            default:
            begin
                thr = 0; eta_min = 256; hits = 1; limit = 64;
            end
        endcase
        write_reg(CFG_CHARGE_THRESHOLD, thr);
        write_reg(CFG_ETA_MINIMUM, eta_min);
        write_reg(CFG_MIN_HITS_PER_SIDE, hits);
        write_reg(CFG_MAX_TIME_DIFFERENCE, limit);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        out_payload_t got;
        out_payload_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (event_summaries_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = event_summaries_due.pop_front();
                compare_field("mean_time_a", $signed(want.mean_time_a), $signed(got.mean_time_a));
                compare_field("mean_time_c", $signed(want.mean_time_c), $signed(got.mean_time_c));
                compare_field("hits_a", want.hits_a, got.hits_a);
                compare_field("hits_c", want.hits_c, got.hits_c);
                compare_field("time_difference", $signed(want.time_difference),
                              $signed(got.time_difference));
                compare_field("difference_valid", want.difference_valid, got.difference_valid);
                compare_field("pass_cut", want.pass_cut, got.pass_cut);
                compare_field("too_many_cells", want.too_many_cells, got.too_many_cells);
                results_checked++;
            end
        end
    end

    // output back-pressure, with one long hold once traffic is flowing
    initial
    begin : drive_ready
        int stall_left;
        int held;
        logic burst;
        stall_left = 0;
        burst      = 1'b0;
        m_tready   <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (!pressure_done && cells_accepted >= 100)
            begin
                m_tready <= 1'b0;
                for (held = 0; held < STALL_CYCLES; held++)
                begin
                    @(negedge clk);
                end
                pressure_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                if ($urandom_range(0, 63) == 0)
                begin
                    burst = !burst;
                end
                if (burst || $urandom_range(0, 99) < 70)
                begin
                    m_tready <= 1'b1;
                end
                else
                begin
                    m_tready   <= 1'b0;
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                             : $urandom_range(0, 3);
                end
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d results still due", cycles,
                 event_summaries_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int phase_start;
        int len;
        int roll;
        s_tvalid        <= 1'b0;
        s_tdata         <= '0;
        s_tlast         <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        cut_charge      = int'(CHARGE_THRESHOLD_RESET);
        cut_eta         = int'(ETA_MINIMUM_RESET);
        need_hits       = int'(MIN_HITS_RESET);
        diff_limit      = int'(MAX_DIFF_RESET);
        sum_a           = 0;
        sum_c           = 0;
        count_a         = 0;
        count_c         = 0;
        cells_accepted  = 0;
        events_sent     = 0;
        saturated_cells = 0;
        events_passed   = 0;
        events_crowded  = 0;

        // lone cell with no valid side: empty summary
        directed_rows.push_back('{make_cell(6, 384, SIDE_NONE, 0, 0, 100), 1'b1, 1'b1,
                                  make_summary(0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0)});
        // cuts at their edges, every kind of rejected cell, mean of extremes
        directed_rows.push_back('{make_cell(6, 384, SIDE_A, 0, 0, 100), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(32767, -1280, SIDE_A, 7, 1, 200), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, -384, SIDE_C, 0, 0, -32768), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(5, 1000, SIDE_C, 1, 0, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, 383, SIDE_C, 1, 0, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, -383, SIDE_C, 1, 1, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, 500, SIDE_C, 8, 0, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, 500, SIDE_C, 15, 1, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, 500, SIDE_C, 3, 2, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, 500, SIDE_C, 3, 3, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, 500, SIDE_BAD_POS, 3, 0, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(100, 500, SIDE_BAD_NEG, 3, 0, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(-32768, 500, SIDE_C, 3, 0, 999), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(50, 1280, SIDE_C, 2, 1, 32767), 1'b1, 1'b1,
                                  make_summary(150, 0, 2, 2, 150, 1'b1, 1'b1, 1'b0)});
        // one side only: not valid
        directed_rows.push_back('{make_cell(7, 384, SIDE_A, 4, 1, -32768), 1'b1, 1'b1,
                                  make_summary(-32768, 0, 1, 0, 0, 1'b0, 1'b0, 1'b0)});
        // end of event on an ignored cell
        directed_rows.push_back('{make_cell(6, 400, SIDE_A, 0, 0, 330), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, 400, SIDE_C, 0, 0, 10), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, 400, SIDE_C, 0, 0, 10), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, 400, SIDE_A, 0, 0, 310), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, 400, 3'sd2, 0, 0, 0), 1'b1, 1'b1,
                                  make_summary(320, 10, 2, 2, 310, 1'b1, 1'b1, 1'b0)});
        // difference equal to the limit fails; negative mean truncates toward zero
        directed_rows.push_back('{make_cell(6, 400, SIDE_A, 0, 0, 313), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, 400, SIDE_A, 0, 0, 313), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, 400, SIDE_C, 0, 0, -7), 1'b0, 1'b0, '0});
        directed_rows.push_back('{make_cell(6, 400, SIDE_C, 0, 0, -8), 1'b1, 1'b1,
                                  make_summary(313, -7, 2, 2, 320, 1'b1, 1'b0, 1'b0)});

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_cell(directed_rows[i].cell_item, directed_rows[i].last, pick_gap(1'b0),
                      directed_rows[i].typed, directed_rows[i].want);
            if (directed_rows[i].last)
            begin
                events_sent++;
            end
        end

        for (phase = 0; phase < 5; phase++)
        begin
            if (phase > 0)
            begin
                wait_idle();
                set_phase(phase);
            end
            phase_start = cells_accepted;
            while (cells_accepted - phase_start < PHASE_CELLS)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                begin
                    len = $urandom_range(1, 8);
                end
                else if (roll < 95)
                begin
                    len = $urandom_range(9, 40);
                end
                else
                begin
                    len = $urandom_range(41, 64);
                end
                run_event(len, 1'b0);
            end
            // saturate both counts
            if (phase == 0 || phase == 2)
            begin
                run_event($urandom_range(520, 560), 1'b1);
            end
        end

        wait_idle();
        $display("Covered %0d events, %0d cells (%0d beyond a full count), %0d results compared",
                 events_sent, cells_accepted, saturated_cells, results_checked);
        $display("%0d events passed the time cut, %0d flagged too many cells, 5 cut settings",
                 events_passed, events_crowded);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/tshtd_pkg.sv
rtl/tshtd_divider.sv
rtl/tshtd_accum.sv
rtl/two_side_hit_time_difference_filter.sv
rtl/tshtd_checker.sv
sim/tb_top.sv
